// ===== hw/rtl/printer_text_normalizer_defines.svh =====
// Assertion macros used by the checker file ptn_props.sv.
`ifndef PRINTER_TEXT_NORMALIZER_DEFINES_SVH
`define PRINTER_TEXT_NORMALIZER_DEFINES_SVH

// Checked outside reset only.
`define PTN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define PTN_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ptn_pkg.sv =====
`timescale 1ns / 1ps

package ptn_pkg;

  // Form length register
  localparam logic [6:0] FL_RESET = 7'd66;
  localparam logic [6:0] FL_MIN   = 7'd10;
  localparam logic [6:0] FL_MAX   = 7'd120;

  // Character codes
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_QM  = 8'h3F;
  localparam logic [7:0] CH_DEL = 8'h7F;

  localparam int TDATA_W = 24;

  // What the back end has to do for one input byte.
  typedef enum logic [1:0] {
    CMD_TEXT,   // up to three literal characters
    CMD_TAB,    // a run of spaces
    CMD_FF      // pad to top of form
  } cmd_kind_t;

  typedef struct packed {
    logic            pfx_q;   // '?' first (broken UTF-8 sequence)
    cmd_kind_t       kind;
    logic [1:0]      len;     // characters used in CMD_TEXT
    logic [2:0][7:0] chars;   // chars[0] goes out first
  } ptn_cmd_t;

endpackage

// ===== hw/rtl/ptn_front.sv =====
`timescale 1ns / 1ps

// Byte decoder: UTF-8 sequence tracking, CR/LF pairing, folding.
module ptn_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              q_full,
  output logic              q_push,
  output ptn_pkg::ptn_cmd_t q_cmd
);

  logic [2:0] seq_need, seq_need_next;
  logic [2:0] seq_got, seq_got_next;
  logic       after_cr, after_cr_next;
  logic [7:0] seq_lead;
  logic [7:0] seq_b1;
  logic       lead_we, b1_we;
  logic       in_seq, bad, cont, eff_acr, accept, has_out;
  logic [2:0] got_inc;
  ptn_pkg::ptn_cmd_t cmd;

  function automatic logic [7:0] fold_latin1(input logic [7:0] c);
    logic [7:0] r;
    case (c) inside
      8'hA0: r = " ";
      8'hA1: r = "!";
      8'hA2: r = "c";
      8'hA3: r = "L";
      8'hA5: r = "Y";
      8'hA7: r = "S";
      8'hA9: r = "C";
      8'hAB, 8'hBB: r = 8'h22;
      8'hAE: r = "R";
      8'hB0: r = "o";
      8'hB1: r = "+";
      8'hB5: r = "u";
      8'hB7: r = ".";
      8'hC7: r = "C";
      8'hD0: r = "D";
      8'hD1: r = "N";
      8'hD7: r = "x";
      8'hD8: r = "O";
      8'hDD: r = "Y";
      8'hDF: r = "s";
      8'hE7: r = "c";
      8'hF0: r = "d";
      8'hF1: r = "n";
      8'hF7: r = "/";
      8'hF8: r = "o";
      8'hFD, 8'hFF: r = "y";
      [8'hC0:8'hC6]: r = "A";
      [8'hC8:8'hCB]: r = "E";
      [8'hCC:8'hCF]: r = "I";
      [8'hD2:8'hD6]: r = "O";
      [8'hD9:8'hDC]: r = "U";
      [8'hE0:8'hE6]: r = "a";
      [8'hE8:8'hEB]: r = "e";
      [8'hEC:8'hEF]: r = "i";
      [8'hF2:8'hF6]: r = "o";
      [8'hF9:8'hFC]: r = "u";
      default: r = ptn_pkg::CH_QM;
    endcase
    return r;
  endfunction

  assign in_seq   = (seq_need != 3'd0);
  assign bad      = in_seq && (in_byte[7:6] != 2'b10);
  assign cont     = in_seq && !bad;
  assign eff_acr  = after_cr && !bad;   // the '?' of a broken sequence clears it
  assign got_inc  = seq_got + 3'd1;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.kind      = ptn_pkg::CMD_TEXT;
    cmd.pfx_q     = bad;
    seq_need_next = seq_need;
    seq_got_next  = seq_got;
    after_cr_next = after_cr;
    lead_we       = 1'b0;
    b1_we         = 1'b0;
    if (cont) begin
      if (got_inc >= seq_need) begin
        // sequence complete: always one piece of text
        seq_need_next = 3'd0;
        seq_got_next  = 3'd0;
        after_cr_next = 1'b0;
        cmd.len       = 2'd1;
        cmd.chars[0]  = ptn_pkg::CH_QM;
        if (seq_got == 3'd1) begin
          if (seq_lead == 8'hC2) begin
            cmd.chars[0] = fold_latin1(in_byte);
          end else if (seq_lead == 8'hC3) begin
            cmd.chars[0] = fold_latin1(in_byte + 8'h40);
          end
        end else if (seq_got == 3'd2 && seq_lead == 8'hE2) begin
          if (seq_b1 == 8'h80) begin
            case (in_byte) inside
              8'h98, 8'h99: cmd.chars[0] = 8'h27;
              8'h9C, 8'h9D: cmd.chars[0] = 8'h22;
              8'h93: cmd.chars[0] = "-";
              8'h94: begin
                cmd.len   = 2'd2;
                cmd.chars = {8'h00, 8'h2D, 8'h2D};
              end
              8'hA6: begin
                cmd.len   = 2'd3;
                cmd.chars = {8'h2E, 8'h2E, 8'h2E};
              end
              8'hA2: cmd.chars[0] = "*";
              default: cmd.chars[0] = ptn_pkg::CH_QM;
            endcase
          end else if (seq_b1 == 8'h82 && in_byte == 8'hAC) begin
            cmd.len   = 2'd3;
            cmd.chars = {8'h52, 8'h55, 8'h45};   // "EUR", E first
          end
        end
      end else begin
        seq_got_next = got_inc;
        b1_we        = (seq_got == 3'd1);
      end
    end else begin
      if (bad) begin
        seq_need_next = 3'd0;
        seq_got_next  = 3'd0;
      end
      after_cr_next = eff_acr;
      case (in_byte) inside
        ptn_pkg::CH_TAB: begin
          cmd.kind      = ptn_pkg::CMD_TAB;
          after_cr_next = 1'b0;
        end
        ptn_pkg::CH_CR: begin
          cmd.len       = 2'd1;
          cmd.chars[0]  = ptn_pkg::CH_CR;
          after_cr_next = 1'b1;
        end
        ptn_pkg::CH_LF: begin
          if (eff_acr) begin
            cmd.len      = 2'd1;
            cmd.chars[0] = ptn_pkg::CH_LF;
          end else begin
            cmd.len      = 2'd2;
            cmd.chars[0] = ptn_pkg::CH_CR;
            cmd.chars[1] = ptn_pkg::CH_LF;
          end
          after_cr_next = 1'b1;
        end
        ptn_pkg::CH_FF: begin
          cmd.kind      = ptn_pkg::CMD_FF;
          after_cr_next = 1'b0;
        end
        ptn_pkg::CH_NUL: begin
        end
        [8'h01:8'h1F], ptn_pkg::CH_DEL: begin
          cmd.len       = 2'd1;
          cmd.chars[0]  = ptn_pkg::CH_QM;
          after_cr_next = 1'b0;
        end
        [8'h20:8'h7E]: begin
          cmd.len       = 2'd1;
          cmd.chars[0]  = in_byte;
          after_cr_next = 1'b0;
        end
        [8'hC0:8'hDF]: begin
          seq_need_next = 3'd2;
          seq_got_next  = 3'd1;
          lead_we       = 1'b1;
        end
        [8'hE0:8'hEF]: begin
          seq_need_next = 3'd3;
          seq_got_next  = 3'd1;
          lead_we       = 1'b1;
        end
        [8'hF0:8'hF7]: begin
          seq_need_next = 3'd4;
          seq_got_next  = 3'd1;
          lead_we       = 1'b1;
        end
        default: begin
          // stray continuation or invalid lead
          seq_need_next = 3'd0;
          seq_got_next  = 3'd0;
          cmd.len       = 2'd1;
          cmd.chars[0]  = ptn_pkg::CH_QM;
          after_cr_next = 1'b0;
        end
      endcase
    end
  end

  assign has_out = cmd.pfx_q || (cmd.kind != ptn_pkg::CMD_TEXT) || (cmd.len != 2'd0);
  assign q_push  = accept && has_out;
  assign q_cmd   = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_need <= 3'd0;
      seq_got  <= 3'd0;
      after_cr <= 1'b0;
    end else if (accept) begin
      seq_need <= seq_need_next;
      seq_got  <= seq_got_next;
      after_cr <= after_cr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && lead_we) begin
      seq_lead <= in_byte;
    end
    if (accept && b1_we) begin
      seq_b1 <= in_byte;
    end
  end

endmodule

// ===== hw/rtl/ptn_queue.sv =====
`timescale 1ns / 1ps

// Small request queue in flops between front and back.
module ptn_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ptn_pkg::ptn_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output ptn_pkg::ptn_cmd_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ptn_pkg::ptn_cmd_t store [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;
  logic          do_push, do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign head    = store[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wptr] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/ptn_back.sv =====
`timescale 1ns / 1ps

// Expands queued requests into output items, tracks line on page.
module ptn_back #(
  parameter int TAB_SPACES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [6:0]        page_len,
  input  logic              q_valid,
  input  ptn_pkg::ptn_cmd_t q_cmd,
  output logic              q_pop,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [ptn_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic              m_axis_tlast
);

  localparam int IDX_W = (TAB_SPACES > 4) ? $clog2(TAB_SPACES) : 2;

  logic [IDX_W-1:0] idx;
  logic             pfx_done;
  logic [6:0]       line_count, line_next;
  logic [7:0]       line_inc;
  logic             ff_go, body_empty, pfx_pend;
  logic             emit, fire, load_ok, item_last;
  logic [7:0]       item_byte;
  logic [6:0]       item_pairs;

  assign load_ok    = !m_axis_tvalid || m_axis_tready;
  assign ff_go      = (line_count != 7'd0) && (line_count < page_len);
  assign body_empty = ((q_cmd.kind == ptn_pkg::CMD_TEXT) && (q_cmd.len == 2'd0)) ||
                      ((q_cmd.kind == ptn_pkg::CMD_FF) && !ff_go);
  assign pfx_pend   = q_cmd.pfx_q && !pfx_done;
  assign line_inc   = {1'b0, line_count} + 8'd1;

  always_comb begin
    emit       = 1'b0;
    item_byte  = ptn_pkg::CH_QM;
    item_pairs = 7'd0;
    item_last  = 1'b0;
    line_next  = line_count;
    if (q_valid) begin
      if (pfx_pend) begin
        emit      = 1'b1;
        item_last = body_empty;
      end else if (!body_empty) begin
        emit = 1'b1;
        case (q_cmd.kind)
          ptn_pkg::CMD_TEXT: begin
            item_byte = q_cmd.chars[idx[1:0]];
            item_last = (idx == IDX_W'(q_cmd.len - 2'd1));
            if (item_byte == ptn_pkg::CH_LF) begin
              line_next = (line_inc >= {1'b0, page_len}) ? 7'd0 : line_inc[6:0];
            end
          end
          ptn_pkg::CMD_TAB: begin
            item_byte = ptn_pkg::CH_SP;
            item_last = (idx == IDX_W'(TAB_SPACES - 1));
          end
          ptn_pkg::CMD_FF: begin
            item_byte  = ptn_pkg::CH_NUL;
            item_pairs = page_len - line_count;
            item_last  = 1'b1;
            line_next  = 7'd0;
          end
          default: begin
            item_last = 1'b1;
          end
        endcase
      end
    end
  end

  assign fire  = emit && load_ok;
  // a request that yields nothing (form feed at top of form, or with the line at or past page_len) leaves at once
  assign q_pop = q_valid && ((fire && item_last) || (!pfx_pend && body_empty));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      line_count    <= 7'd0;
      idx           <= '0;
      pfx_done      <= 1'b0;
    end else begin
      if (load_ok) begin
        m_axis_tvalid <= emit;
      end
      if (fire) begin
        line_count <= line_next;
      end
      if (q_pop) begin
        idx      <= '0;
        pfx_done <= 1'b0;
      end else if (fire) begin
        if (pfx_pend) begin
          pfx_done <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_axis_tdata <= {(ptn_pkg::TDATA_W - 22)'(0), line_next, item_pairs, item_byte};
      m_axis_tlast <= item_last;
    end
  end

endmodule

// ===== hw/rtl/printer_text_normalizer.sv =====
`timescale 1ns / 1ps

// Printer text normalizer. Takes one host text byte per request on s_axis and
// sends printer-safe ASCII on m_axis, keeping count of the line on the page.
// Tab expands to TAB_SPACES spaces, an LF that follows neither CR nor LF gets
// a CR in front, other controls and DEL print as '?', NUL is dropped, and
// UTF-8 two- and three-byte sequences fold to plain ASCII ('?' if unknown). A
// form feed comes out as a single pad item whose pad_pairs field gives the
// number of CR LF pairs to reach top of form; none is sent at top of form or
// when the line already lies at or past the page length. tlast marks the last
// item caused by one input byte; bytes that cause nothing (NUL, lead and inner
// UTF-8 bytes) give no item. Throughput, while m_axis_tready is high: one
// output item per clock, and the front end takes one byte per clock while the
// 4-entry request queue has room, so plain text runs at one byte per cycle. A
// byte that expands into several items holds the back end until all are out
// (up to TAB_SPACES + 1 items for a tab after a broken sequence); the queue
// absorbs short bursts, after that s_axis_tready drops. The page length
// resets to 66; a write outside 10..120 is ignored. Write it only while idle.
module printer_text_normalizer #(
  parameter int TAB_SPACES = 8   // 1..16
) (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,       // page length
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] in_byte
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,    // [7:0] out_byte, [14:8] pad_pairs,
                                       // [21:15] line_now, [23:22] zero
  output logic        m_axis_tlast     // last
);

  logic              page_len_ok;
  logic [6:0]        page_len;
  logic              q_full, q_push, q_pop, q_valid;
  ptn_pkg::ptn_cmd_t q_in, q_head;

  assign page_len_ok = (cfg_wdata >= ptn_pkg::FL_MIN) && (cfg_wdata <= ptn_pkg::FL_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      page_len <= ptn_pkg::FL_RESET;
    end else if (cfg_we && page_len_ok) begin
      page_len <= cfg_wdata;
    end
  end

  // Front end: decodes each byte into one request (or none).
  ptn_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_in)
  );

  // Request queue decouples decode from expansion.
  ptn_queue #(
    .DEPTH (4)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // Back end: one output item per cycle while m_axis_tready allows, into a registered output stage.
  ptn_back #(
    .TAB_SPACES (TAB_SPACES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .page_len      (page_len),
    .q_valid       (q_valid),
    .q_cmd         (q_head),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== hw/rtl/ptn_props.sv =====
`timescale 1ns / 1ps
`include "printer_text_normalizer_defines.svh"

// Port-level checks on the output stream.
module ptn_props (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  `PTN_ASSERT_ALWAYS(a_idle_after_reset, rst |=> !m_axis_tvalid, "output valid after reset")

  `PTN_ASSERT(a_hold_when_stalled, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled item changed")

  `PTN_ASSERT(a_pad_item_shape, m_axis_tvalid && (m_axis_tdata[14:8] != 7'd0) |-> (m_axis_tdata[7:0] == 8'h00) && (m_axis_tdata[21:15] == 7'd0) && m_axis_tlast, "bad pad item")

  `PTN_ASSERT(a_printable, m_axis_tvalid && (m_axis_tdata[14:8] == 7'd0) |-> ((m_axis_tdata[7:0] >= 8'h20) && (m_axis_tdata[7:0] <= 8'h7E)) || (m_axis_tdata[7:0] == 8'h0A) || (m_axis_tdata[7:0] == 8'h0D), "unsafe byte sent")

  `PTN_ASSERT(a_line_range, m_axis_tvalid |-> (m_axis_tdata[21:15] < 7'd120) && (m_axis_tdata[23:22] == 2'b00), "line out of range")

endmodule

bind printer_text_normalizer ptn_props u_props (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
